FILE: hw/rtl/wlc_pkg.sv
package wlc_pkg;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_INVAL = 2'd2,
      MODE_FLUSH = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      logic [31:0] block_number;
   } req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FLUSH,
      ST_COUNT,
      ST_EMIT
   } state_type;

   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
   localparam int QUEUE_DEPTH = 2;
   localparam int RESULT_CAP = 32;

endpackage

FILE: hw/rtl/writeback_lru_cache_tag_controller.sv
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/stall   | mode, block_number
// rsp     | out       | rsp_valid/stall   | slot .. writeback_count
// Read, write or invalidate: the slot scan over the tag and stamp registers,
// a decide step and the dirty count pass, then the final result.
// Flush: the dirty count pass, then one write-back result per dirty slot up to
// RESULT_CAP, or a single final result with nothing dirty; rsp_stall holds it.
// Reset is synchronous and clears all marks, the stamp clock and the counters.
// A two-entry queue takes new items while the engine works or rsp is stalled.
module writeback_lru_cache_tag_controller #(
   parameter int SLOT_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_block_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_slot,
   output logic        rsp_hit,
   output logic        rsp_write_back,
   output logic [31:0] rsp_write_back_block,
   output logic        rsp_fill,
   output logic        rsp_evicted,
   output logic        rsp_last,
   output logic [5:0]  rsp_dirty_slots,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count,
   output logic [31:0] rsp_eviction_count,
   output logic [31:0] rsp_writeback_count
);

   logic             q_valid, q_take;
   wlc_pkg::req_type q_item;

   wlc_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_mode, .req_block_number,
      .q_valid, .q_item, .q_take
   );

   wlc_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock, .reset, .q_valid, .q_item, .q_take,
      .rsp_valid, .rsp_stall, .rsp_slot, .rsp_hit, .rsp_write_back,
      .rsp_write_back_block, .rsp_fill, .rsp_evicted, .rsp_last,
      .rsp_dirty_slots, .rsp_hit_count, .rsp_miss_count,
      .rsp_eviction_count, .rsp_writeback_count
   );

endmodule

FILE: hw/rtl/wlc_front.sv
module wlc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [31:0]      req_block_number,
   output logic             q_valid,
   output wlc_pkg::req_type q_item,
   input  logic             q_take
);

   wlc_pkg::req_type entry_ff [wlc_pkg::QUEUE_DEPTH];
   logic             rd_ptr_ff, rd_ptr_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign req_stall = (count_ff == 2'(wlc_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = q_take && q_valid;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{mode: wlc_pkg::mode_type'(req_mode),
                                  block_number: req_block_number};
      end
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) count_ff <= 2'(wlc_pkg::QUEUE_DEPTH);
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

   property p_pop_nonempty;
      @(posedge clock) disable iff (reset) pop |-> count_ff != 2'd0;
   endproperty
   a_pop_nonempty: assert property (p_pop_nonempty) else $error("pop when empty");

   property p_push_full;
      @(posedge clock) disable iff (reset)
         (count_ff == 2'(wlc_pkg::QUEUE_DEPTH) && !pop) |=> count_ff == 2'(wlc_pkg::QUEUE_DEPTH);
   endproperty
   a_push_full: assert property (p_push_full) else $error("full queue lost entry");

endmodule

FILE: hw/rtl/wlc_back.sv
module wlc_back #(
   parameter int SLOT_COUNT = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  wlc_pkg::req_type q_item,
   output logic             q_take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [4:0]       rsp_slot,
   output logic             rsp_hit,
   output logic             rsp_write_back,
   output logic [31:0]      rsp_write_back_block,
   output logic             rsp_fill,
   output logic             rsp_evicted,
   output logic             rsp_last,
   output logic [5:0]       rsp_dirty_slots,
   output logic [31:0]      rsp_hit_count,
   output logic [31:0]      rsp_miss_count,
   output logic [31:0]      rsp_eviction_count,
   output logic [31:0]      rsp_writeback_count
);

   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);

   logic [31:0] tag_ff    [SLOT_COUNT];
   logic [63:0] stamp_ff  [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] valid_ff, dirty_ff;
   logic [63:0] clock_ff;
   logic [31:0] hits_ff, miss_ff, evict_ff, wb_ff;

   wlc_pkg::state_type state_ff, state_in;
   wlc_pkg::req_type   cur_ff;
   logic [IW:0]        idx_ff;
   logic               found_ff;
   logic [IW-1:0]      found_idx_ff;
   logic               free_ff;
   logic [IW-1:0]      free_idx_ff;
   logic [IW-1:0]      old_idx_ff;
   logic [63:0]        old_stamp_ff;
   logic [CW-1:0]      dcount_ff;
   logic [CW-1:0]      sent_ff;
   logic [CW-1:0]      flush_n_ff;

   logic               out_valid_ff;
   logic [4:0]         o_slot_ff;
   logic               o_hit_ff, o_wb_ff, o_fill_ff, o_ev_ff, o_last_ff;
   logic [31:0]        o_wbb_ff;

   logic [IW-1:0] ix;
   logic          scan_end;
   logic          out_free;
   logic          slot_dirty;
   logic [CW-1:0] cnt_now;
   logic [CW-1:0] flush_n;
   logic          flush_show;
   logic          flush_done;
   logic          show;

   // A result waits in the output register, and no new item is taken while it
   // is stalled, so the counters and the dirty count hold still beside it.
   assign ix         = idx_ff[IW-1:0];
   assign scan_end   = (idx_ff == (IW+1)'(SLOT_COUNT - 1));
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign q_take     = (state_ff == wlc_pkg::ST_IDLE) && out_free;
   assign slot_dirty = valid_ff[ix] && dirty_ff[ix];
   assign cnt_now    = dcount_ff + CW'(slot_dirty);
   assign flush_n    = (int'(cnt_now) > wlc_pkg::RESULT_CAP) ?
                       CW'(wlc_pkg::RESULT_CAP) : cnt_now;
   assign flush_show = (state_ff == wlc_pkg::ST_FLUSH) && out_free && slot_dirty;
   assign flush_done = flush_show && (sent_ff + CW'(1) == flush_n_ff);
   assign show       = flush_show || ((state_ff == wlc_pkg::ST_EMIT) && out_free);

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == wlc_pkg::CNT_MAX) ? v : v + 32'd1;
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [CW-1:0] n);
      logic [32:0] sum;
      sum = {1'b0, v} + 33'(n);
      return sum[32] ? wlc_pkg::CNT_MAX : sum[31:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wlc_pkg::ST_IDLE: begin
            if (q_valid && out_free) begin
               state_in = (q_item.mode == wlc_pkg::MODE_FLUSH) ?
                          wlc_pkg::ST_COUNT : wlc_pkg::ST_SCAN;
            end
         end
         wlc_pkg::ST_SCAN:   if (scan_end) state_in = wlc_pkg::ST_DECIDE;
         wlc_pkg::ST_DECIDE: state_in = wlc_pkg::ST_COUNT;
         wlc_pkg::ST_FLUSH:  if (flush_done) state_in = wlc_pkg::ST_IDLE;
         wlc_pkg::ST_COUNT: begin
            if (scan_end) begin
               state_in = (cur_ff.mode == wlc_pkg::MODE_FLUSH && flush_n != '0) ?
                          wlc_pkg::ST_FLUSH : wlc_pkg::ST_EMIT;
            end
         end
         wlc_pkg::ST_EMIT:   if (out_free) state_in = wlc_pkg::ST_IDLE;
         default:            state_in = wlc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wlc_pkg::ST_IDLE;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         clock_ff     <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         evict_ff     <= '0;
         wb_ff        <= '0;
         dcount_ff    <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tag_ff[i]   <= '0;
            stamp_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= show || (out_valid_ff && rsp_stall);
         unique case (state_ff)
            wlc_pkg::ST_IDLE: begin
               if (q_valid && out_free) begin
                  cur_ff     <= q_item;
                  idx_ff     <= '0;
                  found_ff   <= 1'b0;
                  free_ff    <= 1'b0;
                  old_idx_ff <= '0;
                  dcount_ff  <= '0;
               end
            end
            wlc_pkg::ST_SCAN: begin
               if (valid_ff[ix] && tag_ff[ix] == cur_ff.block_number && !found_ff) begin
                  found_ff     <= 1'b1;
                  found_idx_ff <= ix;
               end
               if (!valid_ff[ix] && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= ix;
               end
               if (idx_ff == '0 || stamp_ff[ix] < old_stamp_ff) begin
                  old_idx_ff   <= ix;
                  old_stamp_ff <= stamp_ff[ix];
               end
               idx_ff <= scan_end ? '0 : idx_ff + (IW+1)'(1);
            end
            wlc_pkg::ST_DECIDE: begin
               o_last_ff <= 1'b1;
               o_fill_ff <= 1'b0;
               o_ev_ff   <= 1'b0;
               o_wb_ff   <= 1'b0;
               o_wbb_ff  <= '0;
               o_hit_ff  <= 1'b0;
               o_slot_ff <= '0;
               if (cur_ff.mode == wlc_pkg::MODE_INVAL) begin
                  if (found_ff) begin
                     o_slot_ff <= 5'(found_idx_ff);
                     o_hit_ff  <= 1'b1;
                     if (dirty_ff[found_idx_ff]) begin
                        o_wb_ff  <= 1'b1;
                        o_wbb_ff <= tag_ff[found_idx_ff];
                        wb_ff    <= sat_inc(wb_ff);
                     end
                     valid_ff[found_idx_ff] <= 1'b0;
                     dirty_ff[found_idx_ff] <= 1'b0;
                  end
               end else if (found_ff) begin
                  o_slot_ff <= 5'(found_idx_ff);
                  o_hit_ff  <= 1'b1;
                  if (cur_ff.mode == wlc_pkg::MODE_READ) hits_ff <= sat_inc(hits_ff);
                  else dirty_ff[found_idx_ff] <= 1'b1;
                  stamp_ff[found_idx_ff] <= clock_ff + 64'd1;
                  clock_ff <= clock_ff + 64'd1;
               end else begin : alloc
                  logic [IW-1:0] v;
                  v = free_ff ? free_idx_ff : old_idx_ff;
                  o_slot_ff <= 5'(v);
                  o_fill_ff <= (cur_ff.mode == wlc_pkg::MODE_READ);
                  if (valid_ff[v]) begin
                     o_ev_ff  <= 1'b1;
                     evict_ff <= sat_inc(evict_ff);
                     if (dirty_ff[v]) begin
                        o_wb_ff  <= 1'b1;
                        o_wbb_ff <= tag_ff[v];
                        wb_ff    <= sat_inc(wb_ff);
                     end
                  end
                  if (cur_ff.mode == wlc_pkg::MODE_READ) miss_ff <= sat_inc(miss_ff);
                  tag_ff[v]   <= cur_ff.block_number;
                  valid_ff[v] <= 1'b1;
                  dirty_ff[v] <= (cur_ff.mode == wlc_pkg::MODE_WRITE);
                  stamp_ff[v] <= clock_ff + 64'd1;
                  clock_ff    <= clock_ff + 64'd1;
               end
            end
            wlc_pkg::ST_FLUSH: begin
               if (out_free) begin
                  if (slot_dirty) begin
                     o_slot_ff <= 5'(ix);
                     o_hit_ff  <= 1'b0;
                     o_wb_ff   <= 1'b1;
                     o_wbb_ff  <= tag_ff[ix];
                     o_fill_ff <= 1'b0;
                     o_ev_ff   <= 1'b0;
                     o_last_ff <= (sent_ff + CW'(1) == flush_n_ff);
                     dirty_ff[ix] <= 1'b0;
                     sent_ff   <= sent_ff + CW'(1);
                  end
                  idx_ff <= scan_end ? '0 : idx_ff + (IW+1)'(1);
               end
            end
            wlc_pkg::ST_COUNT: begin
               // A flush settles its write-back count and the dirty count before
               // the first result goes out, so every result carries final values.
               if (scan_end && cur_ff.mode == wlc_pkg::MODE_FLUSH) begin
                  dcount_ff  <= cnt_now - flush_n;
                  wb_ff      <= sat_add(wb_ff, flush_n);
                  flush_n_ff <= flush_n;
                  sent_ff    <= '0;
               end else begin
                  dcount_ff <= cnt_now;
               end
               idx_ff <= scan_end ? '0 : idx_ff + (IW+1)'(1);
            end
            wlc_pkg::ST_EMIT: begin
               if (out_free) begin
                  o_last_ff <= 1'b1;
                  if (cur_ff.mode == wlc_pkg::MODE_FLUSH) begin
                     o_slot_ff <= '0;
                     o_hit_ff  <= 1'b0;
                     o_wb_ff   <= 1'b0;
                     o_wbb_ff  <= '0;
                     o_fill_ff <= 1'b0;
                     o_ev_ff   <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_slot             = o_slot_ff;
   assign rsp_hit              = o_hit_ff;
   assign rsp_write_back       = o_wb_ff;
   assign rsp_write_back_block = o_wbb_ff;
   assign rsp_fill             = o_fill_ff;
   assign rsp_evicted          = o_ev_ff;
   assign rsp_last             = o_last_ff;
   assign rsp_dirty_slots      = 6'(dcount_ff);
   assign rsp_hit_count        = hits_ff;
   assign rsp_miss_count       = miss_ff;
   assign rsp_eviction_count   = evict_ff;
   assign rsp_writeback_count  = wb_ff;

   property p_emit_last;
      @(posedge clock) disable iff (reset)
         (state_ff == wlc_pkg::ST_EMIT && out_free) |=> rsp_valid && rsp_last;
   endproperty
   a_emit_last: assert property (p_emit_last) else $error("final result missing");

   property p_wbb_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_write_back) |-> rsp_write_back_block == '0;
   endproperty
   a_wbb_zero: assert property (p_wbb_zero) else $error("stray write-back block");

   property p_fill_miss;
      @(posedge clock) disable iff (reset) (rsp_valid && rsp_fill) |-> !rsp_hit;
   endproperty
   a_fill_miss: assert property (p_fill_miss) else $error("fill on hit");

   property p_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_slot) &&
            $stable(rsp_write_back_block) && $stable(rsp_last) &&
            $stable(rsp_dirty_slots) && $stable(rsp_writeback_count);
   endproperty
   a_hold: assert property (p_hold) else $error("stalled result changed");

endmodule
